FILE: hdl/clb_pkg.sv
// shared types, byte constants and the per-byte decision function
// for the comment and literal blanker; no dependencies
`timescale 1ns / 1ps

package clb_pkg;

    // scan modes of the source text
    typedef enum logic [2:0] {
        MODE_CODE  = 3'd0,
        MODE_LINE  = 3'd1,
        MODE_BLOCK = 3'd2,
        MODE_STR   = 3'd3,
        MODE_CHR   = 3'd4
    } t_scan_mode;

    localparam logic [7:0] CHR_SLASH = 8'h2F;
    localparam logic [7:0] CHR_STAR  = 8'h2A;
    localparam logic [7:0] CHR_BLANK = 8'h20;
    localparam logic [7:0] CHR_NL    = 8'h0A;
    localparam logic [7:0] CHR_BSL   = 8'h5C;
    localparam logic [7:0] CHR_DQ    = 8'h22;
    localparam logic [7:0] CHR_SQ    = 8'h27;

    // result queue geometry
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    // outcome of deciding one byte
    typedef struct packed {
        logic [7:0] out_byte;
        t_scan_mode mode;
        logic       take_next;
    } t_decision;

    // one queued result item
    typedef struct packed {
        logic [7:0] clean_byte;
        logic       final_byte;
    } t_result;

    // decide byte c with lookahead nx in mode m
    function automatic t_decision decide(t_scan_mode m, logic [7:0] c, logic [7:0] nx);
        t_decision d;
        d.out_byte  = CHR_BLANK;
        d.mode      = m;
        d.take_next = 1'b0;
        case (m)
            MODE_LINE: begin
                if (c == CHR_NL) begin
                    d.mode     = MODE_CODE;
                    d.out_byte = c;
                end
            end
            MODE_BLOCK: begin
                if (c == CHR_STAR && nx == CHR_SLASH) begin
                    d.take_next = 1'b1;
                    d.mode      = MODE_CODE;
                end else if (c == CHR_NL) begin
                    d.out_byte = c;
                end
            end
            MODE_STR, MODE_CHR: begin
                if (c == CHR_BSL) begin
                    d.take_next = 1'b1;
                end else if ((m == MODE_STR && c == CHR_DQ) ||
                             (m == MODE_CHR && c == CHR_SQ)) begin
                    d.mode     = MODE_CODE;
                    d.out_byte = c;
                end
            end
            default: begin
                // code, and any stray code value
                if (c == CHR_SLASH && nx == CHR_SLASH) begin
                    d.mode = MODE_LINE;
                end else if (c == CHR_SLASH && nx == CHR_STAR) begin
                    d.mode = MODE_BLOCK;
                end else begin
                    d.out_byte = c;
                    if (c == CHR_DQ) begin
                        d.mode = MODE_STR;
                    end else if (c == CHR_SQ) begin
                        d.mode = MODE_CHR;
                    end else begin
                        d.mode = MODE_CODE;
                    end
                end
            end
        endcase
        return d;
    endfunction

endpackage

FILE: hdl/clb_text_if.sv
// source text channel: valid/ready handshake with one byte and an end mark
// no dependencies
`timescale 1ns / 1ps

interface clb_text_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       end_of_text;

    modport source (output valid, output text_byte, output end_of_text, input ready);
    modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

FILE: hdl/clb_clean_if.sv
// cleaned text channel: valid/ready handshake with one byte and a final mark
// no dependencies
`timescale 1ns / 1ps

interface clb_clean_if;
    logic       valid;
    logic       ready;
    logic [7:0] clean_byte;
    logic       final_byte;

    modport source (output valid, output clean_byte, output final_byte, input ready);
    modport sink   (input valid, input clean_byte, input final_byte, output ready);
endinterface

FILE: hdl/c_comment_literal_blanker_unit.sv
// top level of the comment and literal blanker
// depends on clb_pkg, clb_text_if and clb_clean_if
`timescale 1ns / 1ps

// channel   direction  payload                      handshake
// i_text    in         text_byte[7:0], end_of_text  valid/ready
// o_clean   out        clean_byte[7:0], final_byte  valid/ready
//
// one source item is taken per cycle while the queue has room; each byte's result
// is queued as the next byte is taken, and the final item also queues its own result
// the scan state and the held byte update in the cycle an item is taken
// results wait in a four-entry queue; input is taken while at least two slots are free
// synchronous active-low reset clears mode, held byte flags and the queue

module c_comment_literal_blanker_unit
    import clb_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    clb_text_if.sink    i_text,
    clb_clean_if.source o_clean
);

    t_scan_mode r_mode, n_mode;
    logic [7:0] r_held;
    logic       r_held_valid, n_held_valid;
    logic       r_held_cons, n_held_cons;

    t_result    r_queue [QDEPTH];
    logic [QAW-1:0] r_wptr, r_rptr;
    logic [QAW:0]   r_count, n_count;

    logic       in_acc, out_acc;
    t_decision  dec1, dec2;
    t_scan_mode mode1;
    logic       cons1;
    t_result    res_a, res_b;
    logic [1:0] push_n;

    // handshakes
    assign i_text.ready = (r_count <= (QAW+1)'(QDEPTH - 2));
    assign in_acc       = i_text.valid && i_text.ready;
    assign o_clean.valid      = (r_count != '0);
    assign o_clean.clean_byte = r_queue[r_rptr].clean_byte;
    assign o_clean.final_byte = r_queue[r_rptr].final_byte;
    assign out_acc      = o_clean.valid && o_clean.ready;

    // decide the held byte against the new byte, then the new byte at the end
    always_comb begin
        dec1 = decide(r_mode, r_held, i_text.text_byte);
        if (r_held_cons) begin
            dec1.out_byte  = CHR_BLANK;
            dec1.mode      = r_mode;
            dec1.take_next = 1'b0;
        end
        if (r_held_valid) begin
            mode1 = dec1.mode;
            cons1 = dec1.take_next;
        end else begin
            mode1 = r_mode;
            cons1 = 1'b0;
        end
        dec2 = decide(mode1, i_text.text_byte, 8'h00);
        if (cons1) begin
            dec2.out_byte = CHR_BLANK;
        end

        // results in order; the final one takes the first slot only when no byte is held
        res_a.clean_byte = dec1.out_byte;
        res_a.final_byte = 1'b0;
        res_b.clean_byte = dec2.out_byte;
        res_b.final_byte = 1'b1;
        if (!r_held_valid) begin
            res_a = res_b;
        end
        push_n = 2'd0;
        if (in_acc) begin
            push_n = {1'b0, r_held_valid} + {1'b0, i_text.end_of_text};
        end

        // next scan state
        n_mode       = r_mode;
        n_held_valid = r_held_valid;
        n_held_cons  = r_held_cons;
        if (in_acc) begin
            if (i_text.end_of_text) begin
                n_mode       = MODE_CODE;
                n_held_valid = 1'b0;
                n_held_cons  = 1'b0;
            end else begin
                n_mode       = mode1;
                n_held_valid = 1'b1;
                n_held_cons  = cons1;
            end
        end

        n_count = r_count + (QAW+1)'(push_n) - (QAW+1)'(out_acc);
    end

    // scan state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= MODE_CODE;
            r_held_valid <= 1'b0;
            r_held_cons  <= 1'b0;
        end else begin
            r_mode       <= n_mode;
            r_held_valid <= n_held_valid;
            r_held_cons  <= n_held_cons;
        end
    end

    // held byte payload
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_held <= i_text.end_of_text ? 8'h00 : i_text.text_byte;
        end
    end

    // result queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= r_wptr + QAW'(push_n);
            r_rptr  <= r_rptr + QAW'(out_acc);
            r_count <= n_count;
        end
    end

    // result queue entries
    always_ff @(posedge i_clk) begin
        if (push_n != 2'd0) begin
            r_queue[r_wptr] <= res_a;
        end
        if (push_n == 2'd2) begin
            r_queue[r_wptr + QAW'(1)] <= res_b;
        end
    end

endmodule

FILE: dv/tb.sv
// testbench for c_comment_literal_blanker_unit: directed texts, then random C-like texts
// depends on clb_pkg, clb_text_if, clb_clean_if and the blanker top level
`timescale 1ns / 1ps

module tb
    import clb_pkg::*;
();

    // directed stimulus row: byte, end mark, and an optional typed-in final result
    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_text;
        logic       typed;
        logic [7:0] want;
    } t_row;

    localparam int   N_DIRECTED = 24;
    localparam int   N_RANDOM   = 500;
    localparam logic [7:0] CHR_A = 8'h41;
    localparam logic [7:0] CHR_B = 8'h62;
    localparam logic [7:0] CHR_C = 8'h63;
    localparam logic [7:0] CHR_X = 8'h78;

    // single-byte texts, quirk closer, line comment, block comment with a star
    // at the end, string with escape, escape at the end, char literal
    localparam t_row DIRECTED_ROWS [N_DIRECTED] = '{
        '{CHR_A,     1'b1, 1'b1, CHR_A},
        '{8'h00,     1'b1, 1'b1, 8'h00},
        '{8'hFF,     1'b1, 1'b1, 8'hFF},
        '{CHR_SLASH, 1'b0, 1'b0, 8'h00},
        '{CHR_STAR,  1'b0, 1'b0, 8'h00},
        '{CHR_SLASH, 1'b1, 1'b0, 8'h00},
        '{CHR_SLASH, 1'b0, 1'b0, 8'h00},
        '{CHR_SLASH, 1'b0, 1'b0, 8'h00},
        '{CHR_C,     1'b0, 1'b0, 8'h00},
        '{CHR_NL,    1'b0, 1'b0, 8'h00},
        '{CHR_B,     1'b1, 1'b0, 8'h00},
        '{CHR_SLASH, 1'b0, 1'b0, 8'h00},
        '{CHR_STAR,  1'b0, 1'b0, 8'h00},
        '{CHR_NL,    1'b0, 1'b0, 8'h00},
        '{CHR_STAR,  1'b1, 1'b0, 8'h00},
        '{CHR_DQ,    1'b0, 1'b0, 8'h00},
        '{CHR_BSL,   1'b0, 1'b0, 8'h00},
        '{CHR_DQ,    1'b0, 1'b0, 8'h00},
        '{CHR_DQ,    1'b1, 1'b0, 8'h00},
        '{CHR_SQ,    1'b0, 1'b0, 8'h00},
        '{CHR_BSL,   1'b1, 1'b1, CHR_BLANK},
        '{CHR_SQ,    1'b0, 1'b0, 8'h00},
        '{CHR_X,     1'b0, 1'b0, 8'h00},
        '{CHR_SQ,    1'b1, 1'b0, 8'h00}
    };

    logic clk = 1'b0;
    logic rst_n;

    clb_text_if  text_ch ();
    clb_clean_if clean_ch ();

    c_comment_literal_blanker_unit u_top (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_text  (text_ch.sink),
        .o_clean (clean_ch.source)
    );

    // predictor state
    t_scan_mode pred_mode;
    logic [7:0] pred_held;
    logic       pred_held_ok;
    logic       pred_held_used;

    t_result    clean_q [$];
    logic [7:0] text_buf [$];

    logic       item_typed;
    logic [7:0] item_want;
    logic       no_idle;
    int         n_errors;
    int         n_texts;
    int         n_bytes_in;
    int         n_checked;

    // 10 ns clock
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // hard limit on run time
    initial begin
        #2000000;
        $display("timeout with %0d cleaned bytes still expected", clean_q.size());
        $display("CHECKS FAILED");
        $finish;
    end

    task automatic report_mismatch(input string what);
        n_errors++;
        $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    function automatic int idle_draw();
        return no_idle ? 0 : $urandom_range(0, 5);
    endfunction

    // decide one byte with its lookahead in the current scan mode
    function automatic logic [7:0] scan_byte(input logic [7:0] c, input logic [7:0] nx,
                                             output logic swallow);
        swallow = 1'b0;
        case (pred_mode)
            MODE_LINE: begin
                if (c == CHR_NL) begin
                    pred_mode = MODE_CODE;
                    return c;
                end
                return CHR_BLANK;
            end
            MODE_BLOCK: begin
                if (c == CHR_STAR && nx == CHR_SLASH) begin
                    swallow   = 1'b1;
                    pred_mode = MODE_CODE;
                    return CHR_BLANK;
                end
                return (c == CHR_NL) ? c : CHR_BLANK;
            end
            MODE_STR, MODE_CHR: begin
                if (c == CHR_BSL) begin
                    swallow = 1'b1;
                    return CHR_BLANK;
                end
                if ((pred_mode == MODE_STR && c == CHR_DQ) ||
                    (pred_mode == MODE_CHR && c == CHR_SQ)) begin
                    pred_mode = MODE_CODE;
                    return c;
                end
                return CHR_BLANK;
            end
            default: begin
                if (c == CHR_SLASH && nx == CHR_SLASH) begin
                    pred_mode = MODE_LINE;
                    return CHR_BLANK;
                end
                if (c == CHR_SLASH && nx == CHR_STAR) begin
                    pred_mode = MODE_BLOCK;
                    return CHR_BLANK;
                end
                if (c == CHR_DQ) begin
                    pred_mode = MODE_STR;
                end else if (c == CHR_SQ) begin
                    pred_mode = MODE_CHR;
                end else begin
                    pred_mode = MODE_CODE;
                end
                return c;
            end
        endcase
    endfunction

    // give out the held byte unless it was swallowed by a closer or escape
    function automatic logic [7:0] release_byte(input logic [7:0] nx, output logic swallow);
        if (pred_held_used) begin
            swallow = 1'b0;
            return CHR_BLANK;
        end
        return scan_byte(pred_held, nx, swallow);
    endfunction

    function automatic void clear_predictor();
        pred_mode      = MODE_CODE;
        pred_held      = 8'h00;
        pred_held_ok   = 1'b0;
        pred_held_used = 1'b0;
    endfunction

    // expected cleaned bytes for one accepted source item
    function automatic void predict_clean(input logic [7:0] b, input logic eot,
                                          input logic typed, input logic [7:0] want);
        logic    swallow;
        t_result r;
        swallow = 1'b0;
        if (pred_held_ok) begin
            r.clean_byte = release_byte(b, swallow);
            r.final_byte = 1'b0;
            clean_q.insert(clean_q.size(), r);
            pred_held_used = swallow;
        end else begin
            pred_held_used = 1'b0;
        end
        pred_held    = b;
        pred_held_ok = 1'b1;
        if (eot) begin
            r.clean_byte = release_byte(8'h00, swallow);
            if (typed) begin
                r.clean_byte = want;
            end
            r.final_byte = 1'b1;
            clean_q.insert(clean_q.size(), r);
            clear_predictor();
        end
    endfunction

    // accepted source items feed the predictor
    always @(posedge clk) begin
        if (rst_n && text_ch.valid && text_ch.ready) begin
            n_bytes_in++;
            predict_clean(text_ch.text_byte, text_ch.end_of_text, item_typed, item_want);
        end
    end

    // accepted cleaned bytes are checked against the oldest expectation
    always @(posedge clk) begin
        t_result e;
        if (rst_n && clean_ch.valid && clean_ch.ready) begin
            n_checked++;
            if (clean_q.size() == 0) begin
                report_mismatch($sformatf("unexpected item byte %02h final %0b",
                                          clean_ch.clean_byte, clean_ch.final_byte));
            end else begin
                e = clean_q.pop_front();
                if (clean_ch.clean_byte !== e.clean_byte) begin
                    report_mismatch($sformatf("clean_byte %02h, want %02h",
                                              clean_ch.clean_byte, e.clean_byte));
                end
                if (clean_ch.final_byte !== e.final_byte) begin
                    report_mismatch($sformatf("final_byte %0b, want %0b",
                                              clean_ch.final_byte, e.final_byte));
                end
            end
        end
    end

    // sink side: random stall before each item
    initial begin
        int stall;
        clean_ch.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            stall = idle_draw();
            if (stall > 0) begin
                clean_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            clean_ch.ready <= 1'b1;
            @(posedge clk);
            while (!clean_ch.valid) @(posedge clk);
        end
    end

    // drive one source item after a random gap and wait for it to be taken
    task automatic send_byte(input logic [7:0] b, input logic eot,
                             input logic typed, input logic [7:0] want);
        int gap;
        gap = idle_draw();
        if (gap > 0) begin
            text_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        text_ch.valid       <= 1'b1;
        text_ch.text_byte   <= b;
        text_ch.end_of_text <= eot;
        item_typed          <= typed;
        item_want           <= want;
        @(posedge clk);
        while (!text_ch.ready) @(posedge clk);
    endtask

    // append one byte to the text under construction
    function automatic void append_byte(input logic [7:0] c);
        text_buf.insert(text_buf.size(), c);
    endfunction

    // byte likely to matter inside a comment or literal
    function automatic logic [7:0] inner_byte();
        case ($urandom_range(0, 9))
            0: return CHR_STAR;
            1: return CHR_SLASH;
            2: return CHR_BSL;
            3: return CHR_NL;
            4: return CHR_DQ;
            5: return CHR_SQ;
            6: return 8'($urandom_range(0, 255));
            default: return 8'($urandom_range(8'h20, 8'h7E));
        endcase
    endfunction

    // literal body with escapes, closing quote kept out of the body
    function automatic void add_literal(input logic [7:0] quote);
        int         n;
        logic [7:0] c;
        n = $urandom_range(0, 5);
        append_byte(quote);
        repeat (n) begin
            c = inner_byte();
            if (c == CHR_BSL) begin
                append_byte(c);
                append_byte(inner_byte());
            end else begin
                append_byte((c == quote) ? CHR_X : c);
            end
        end
        append_byte(quote);
    endfunction

    // append one token of C-like text
    function automatic void add_token();
        int n;
        case ($urandom_range(0, 7))
            0, 1: begin
                n = $urandom_range(1, 4);
                repeat (n) begin
                    append_byte(($urandom_range(0, 3) == 0) ? inner_byte()
                                : 8'($urandom_range(8'h61, 8'h7A)));
                end
            end
            2: begin
                n = $urandom_range(0, 5);
                append_byte(CHR_SLASH);
                append_byte(CHR_SLASH);
                repeat (n) append_byte(inner_byte());
                append_byte(CHR_NL);
            end
            3: begin
                n = $urandom_range(0, 5);
                append_byte(CHR_SLASH);
                append_byte(CHR_STAR);
                repeat (n) append_byte(inner_byte());
                append_byte(CHR_STAR);
                append_byte(CHR_SLASH);
            end
            4: add_literal(CHR_DQ);
            5: add_literal(CHR_SQ);
            6: append_byte(inner_byte());
            default: begin
                n = $urandom_range(1, 3);
                repeat (n) append_byte(8'($urandom_range(0, 255)));
            end
        endcase
    endfunction

    // main sequence
    initial begin
        int n_random;
        int n_tokens;
        int cut;
        int wait_cycles;
        n_errors   = 0;
        n_texts    = 0;
        n_bytes_in = 0;
        n_checked  = 0;
        n_random   = 0;
        no_idle    = 1'b0;
        clear_predictor();
        rst_n               <= 1'b0;
        text_ch.valid       <= 1'b0;
        text_ch.text_byte   <= 8'h00;
        text_ch.end_of_text <= 1'b0;
        item_typed          <= 1'b0;
        item_want           <= 8'h00;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed texts
        foreach (DIRECTED_ROWS[i]) begin
            send_byte(DIRECTED_ROWS[i].text_byte, DIRECTED_ROWS[i].end_of_text,
                      DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);
            if (DIRECTED_ROWS[i].end_of_text) begin
                n_texts++;
            end
        end

        // random texts, mostly well-formed, some cut short
        while (n_random < N_RANDOM) begin
            text_buf.delete();
            no_idle  = ($urandom_range(0, 3) == 0);
            n_tokens = $urandom_range(1, 6);
            repeat (n_tokens) add_token();
            if ($urandom_range(0, 5) == 0) begin
                cut = $urandom_range(1, text_buf.size());
                while (text_buf.size() > cut) text_buf.delete(text_buf.size() - 1);
            end
            foreach (text_buf[i]) begin
                send_byte(text_buf[i], (i == text_buf.size() - 1), 1'b0, 8'h00);
                n_random++;
            end
            n_texts++;
        end
        no_idle = 1'b0;
        text_ch.valid <= 1'b0;

        // drain
        wait_cycles = 0;
        while (clean_q.size() > 0 && wait_cycles < 2000) begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (20) @(posedge clk);
        if (clean_q.size() != 0) begin
            report_mismatch($sformatf("%0d cleaned bytes never arrived", clean_q.size()));
        end

        $display("sent %0d source texts (%0d bytes) through comments, literals and escapes",
                 n_texts, n_bytes_in);
        $display("checked %0d cleaned bytes, %0d mismatches", n_checked, n_errors);
        if (n_errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
